FILE: hw/rtl/trapezoidal_velocity_profile_unit_assert.svh
// Assertion macros for the trapezoidal velocity profile unit.
// Included by the checker; needs nothing else.
`ifndef TRAPEZOIDAL_VELOCITY_PROFILE_UNIT_ASSERT_SVH
`define TRAPEZOIDAL_VELOCITY_PROFILE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TVP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tvp_pkg.sv
// Shared constants and types of the trapezoidal velocity profile unit.
// No dependencies.
package tvp_pkg;

  localparam int LEN_W     = 24;
  localparam int ACC_W     = 24;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam int SPEED_BITS_DEF     = 24;
  localparam int TIME_FRAC_BITS_DEF = 16;

  localparam int CRUISE_RST = 25600;
  localparam int ACCEL_RST  = 25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATH_LENGTH  = 3'd0,
    REG_START_SPEED  = 3'd1,
    REG_END_SPEED    = 3'd2,
    REG_CRUISE_LIMIT = 3'd3,
    REG_ACCEL_LIMIT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

endpackage

FILE: hw/rtl/tvp_in_if.sv
// Sample input channel: elapsed time with valid/ready.
// Depends on tvp_pkg.
interface tvp_in_if;
  import tvp_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink (input valid, input elapsed_time, output ready);
endinterface

FILE: hw/rtl/tvp_out_if.sv
// Command output channel: speed and phase with valid/ready.
// Depends on tvp_pkg.
interface tvp_out_if #(
  parameter int SPEED_BITS = tvp_pkg::SPEED_BITS_DEF
);
  import tvp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SPEED_BITS-1:0] speed;
  phase_e                phase;

  modport source (output valid, output speed, output phase, input ready);
  modport sink (input valid, input speed, input phase, output ready);
endinterface

FILE: hw/rtl/trapezoidal_velocity_profile_unit.sv
// Top level of the trapezoidal velocity profile unit: config registers and sample pipeline.
// Depends on tvp_pkg, tvp_in_if, tvp_out_if and tvp_deriv.
//
//   Channel  Dir  Payload                        Transfer at clock edge with
//   time_i   in   elapsed_time[31:0]             valid && ready
//   cmd_o    out  speed[SPEED_BITS-1:0], phase   valid && ready
//   cfg_*    in   cfg_idx_i, cfg_data_i          cfg_we_i
//
// One sample per cycle while cmd_o takes results and no recompute holds time_i.ready low;
// a sample reaches cmd_o through four register stages (time register, phase compare,
// acceleration multiply, speed add/saturate).
// Each stage holds its item while the stage ahead cannot advance, so a stall on cmd_o
// backs up stage by stage and bubbles are squeezed out.
// A write to a listed register recomputes the profile in tvp_deriv; time_i.ready
// stays low while it runs, a length bound by the bit-serial divider on an NW-bit
// numerator, NW = max(2*SPEED_BITS,49)+2+TIME_FRAC_BITS.
// Reset loads the register reset values and a zero profile, which is their profile.
module trapezoidal_velocity_profile_unit #(
  parameter int SPEED_BITS     = tvp_pkg::SPEED_BITS_DEF,
  parameter int TIME_FRAC_BITS = tvp_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  tvp_in_if.sink                                       time_i,
  tvp_out_if.source                                    cmd_o,
  input  logic                                         cfg_we_i,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [((SPEED_BITS > tvp_pkg::LEN_W) ? SPEED_BITS : tvp_pkg::LEN_W)-1:0] cfg_data_i
);
  import tvp_pkg::*;

  localparam int SB   = SPEED_BITS;
  localparam int TF   = TIME_FRAC_BITS;
  localparam int PRW  = ACC_W + TIME_W;
  localparam int DRW  = PRW - TF;
  localparam int SUMW = DRW + 1;
  localparam logic [SB-1:0] SPEED_MAX = '1;

  // Configuration registers
  logic [LEN_W-1:0] path_len_q;
  logic [SB-1:0]    start_q, end_q, cruise_q;
  logic [ACC_W-1:0] accel_q, acc_eff;
  logic             cfg_hit;

  // Derived profile
  logic              busy;
  logic [SB-1:0]     peak;
  logic [TIME_W-1:0] ramp_up, total;
  logic [TIME_W:0]   plateau_end;

  // Pipeline stages
  logic              en1, en2, en3, en4;
  logic              v1_q, v2_q, v3_q, v4_q;
  logic [TIME_W-1:0] t1_q, dt2_q, dt2_d;
  phase_e            ph2_q, ph2_d, ph3_q, ph4_q;
  logic [PRW-1:0]    prod3_q;
  logic [SB-1:0]     spd4_q, spd4_d;
  logic [DRW-1:0]    drop;
  logic [SUMW-1:0]   up_sum;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= REG_ACCEL_LIMIT);
  assign acc_eff = (accel_q == '0) ? ACC_W'(1) : accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_len_q <= '0;
      start_q    <= '0;
      end_q      <= '0;
      cruise_q   <= SB'(CRUISE_RST);
      accel_q    <= ACC_W'(ACCEL_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATH_LENGTH:  path_len_q <= cfg_data_i[LEN_W-1:0];
        REG_START_SPEED:  start_q    <= cfg_data_i[SB-1:0];
        REG_END_SPEED:    end_q      <= cfg_data_i[SB-1:0];
        REG_CRUISE_LIMIT: cruise_q   <= cfg_data_i[SB-1:0];
        REG_ACCEL_LIMIT:  accel_q    <= cfg_data_i[ACC_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  tvp_deriv #(
    .SPEED_BITS     (SPEED_BITS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_deriv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (cfg_hit),
    .path_len_i    (path_len_q),
    .start_speed_i (start_q),
    .end_speed_i   (end_q),
    .cruise_lim_i  (cruise_q),
    .accel_i       (acc_eff),
    .busy_o        (busy),
    .peak_o        (peak),
    .ramp_up_o     (ramp_up),
    .plateau_end_o (plateau_end),
    .total_o       (total)
  );

  // Advance a stage when it is empty or the stage ahead advances
  assign en4 = !v4_q || cmd_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign time_i.ready = en1 && !busy;

  // Stage 2: classify the time against the profile breakpoints
  always_comb begin
    if (t1_q < ramp_up) begin
      ph2_d = PH_ACCEL;
    end else if ({1'b0, t1_q} < plateau_end) begin
      ph2_d = PH_CRUISE;
    end else if (t1_q < total) begin
      ph2_d = PH_DECEL;
    end else begin
      ph2_d = PH_DONE;
    end
    dt2_d = (ph2_d == PH_DECEL) ? (t1_q - plateau_end[TIME_W-1:0]) : t1_q;
  end

  // Stage 4: add or subtract the ramp term and saturate, or take the peak or end speed
  assign drop   = prod3_q[PRW-1:TF];
  assign up_sum = SUMW'(start_q) + SUMW'(drop);

  always_comb begin
    unique case (ph3_q)
      PH_ACCEL:  spd4_d = (up_sum > SUMW'(SPEED_MAX)) ? SPEED_MAX : up_sum[SB-1:0];
      PH_CRUISE: spd4_d = peak;
      PH_DECEL:  spd4_d = (drop >= DRW'(peak)) ? '0 : (peak - drop[SB-1:0]);
      PH_DONE:   spd4_d = end_q;
      default:   spd4_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= time_i.valid && time_i.ready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q <= time_i.elapsed_time;
    end
    if (en2) begin
      ph2_q <= ph2_d;
      dt2_q <= dt2_d;
    end
    if (en3) begin
      ph3_q   <= ph2_q;
      prod3_q <= PRW'(acc_eff) * PRW'(dt2_q);
    end
    if (en4) begin
      ph4_q  <= ph3_q;
      spd4_q <= spd4_d;
    end
  end

  assign cmd_o.valid = v4_q;
  assign cmd_o.speed = spd4_q;
  assign cmd_o.phase = ph4_q;

endmodule

FILE: hw/rtl/tvp_deriv.sv
// Profile derivation sequencer: shared multiplier, bit-serial divider and square root.
// Depends on tvp_pkg.
module tvp_deriv #(
  parameter int SPEED_BITS     = tvp_pkg::SPEED_BITS_DEF,
  parameter int TIME_FRAC_BITS = tvp_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tvp_pkg::LEN_W-1:0]   path_len_i,
  input  logic [SPEED_BITS-1:0]       start_speed_i,
  input  logic [SPEED_BITS-1:0]       end_speed_i,
  input  logic [SPEED_BITS-1:0]       cruise_lim_i,
  input  logic [tvp_pkg::ACC_W-1:0]   accel_i,
  output logic                        busy_o,
  output logic [SPEED_BITS-1:0]       peak_o,
  output logic [tvp_pkg::TIME_W-1:0]  ramp_up_o,
  output logic [tvp_pkg::TIME_W:0]    plateau_end_o,
  output logic [tvp_pkg::TIME_W-1:0]  total_o
);
  import tvp_pkg::*;

  localparam int SB  = SPEED_BITS;
  localparam int TF  = TIME_FRAC_BITS;
  localparam int LAW = LEN_W + ACC_W + 1;
  localparam int XW  = ((2 * SB > LAW) ? 2 * SB : LAW) + 2;
  localparam int SQW = (XW + 1) / 2;
  localparam int MW0 = (SB + 1 > ACC_W + 1) ? SB + 1 : ACC_W + 1;
  localparam int MW  = (MW0 > SQW) ? MW0 : SQW;
  localparam int PW  = 2 * MW;
  localparam int DW  = ACC_W + 1 + SB;
  localparam int NW  = XW + TF;
  localparam int CW  = $clog2(NW + 1);
  localparam int BW  = $clog2(SQW);
  localparam logic [SB-1:0] SPEED_MAX = '1;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_M_LEN  = 15'h0002,
    ST_M_SS   = 15'h0004,
    ST_M_EE   = 15'h0008,
    ST_M_CC   = 15'h0010,
    ST_M_DEN  = 15'h0020,
    ST_DECIDE = 15'h0040,
    ST_SQ_MUL = 15'h0080,
    ST_SQ_CHK = 15'h0100,
    ST_DIV_CR = 15'h0200,
    ST_RU_SET = 15'h0400,
    ST_DIV_RU = 15'h0800,
    ST_RD_SET = 15'h1000,
    ST_DIV_RD = 15'h2000,
    ST_TOTAL  = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic [MW-1:0]     mul_a, mul_b;
  logic [PW-1:0]     p_q;
  logic [XW-1:0]     x_q, x_d, y_q, y_d;
  logic [SQW-1:0]    res_q, res_d, cand, sq_final;
  logic [BW-1:0]     bit_q, bit_d;
  logic [NW-1:0]     num_q, num_d;
  logic [DW-1:0]     den_q, den_d, rem_q, rem_d;
  logic [TIME_W-1:0] quo_q, quo_d;
  logic              sat_q, sat_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  logic [SB-1:0]     peak_q, peak_d;
  logic [TIME_W-1:0] ru_q, ru_d, ct_q, ct_d, rd_q, rd_d, tot_q, tot_d;
  logic [TIME_W:0]   pe_q, pe_d;

  logic [ACC_W:0]    acc2;
  logic [DW:0]       rem_sh, rem_nx;
  logic              ge, div_last, in_div;
  logic [TIME_W-1:0] quo_nx, div_res;
  logic              sat_nx;
  logic [TIME_W+1:0] sum3;

  assign acc2 = {accel_i, 1'b0};
  assign cand = res_q | (SQW'(1) << bit_q);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M_LEN: begin
        mul_a = MW'(acc2);
        mul_b = MW'(path_len_i);
      end
      ST_M_SS: begin
        mul_a = MW'(start_speed_i);
        mul_b = MW'(start_speed_i);
      end
      ST_M_EE: begin
        mul_a = MW'(end_speed_i);
        mul_b = MW'(end_speed_i);
      end
      ST_M_CC: begin
        mul_a = MW'(cruise_lim_i);
        mul_b = MW'(cruise_lim_i);
      end
      ST_M_DEN: begin
        mul_a = MW'(acc2);
        mul_b = MW'(cruise_lim_i);
      end
      ST_SQ_MUL: begin
        mul_a = MW'(cand);
        mul_b = MW'(cand);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One restoring divide step per cycle
  assign rem_sh   = {rem_q, num_q[NW-1]};
  assign ge       = rem_sh >= {1'b0, den_q};
  assign rem_nx   = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_nx   = {quo_q[TIME_W-2:0], ge};
  assign sat_nx   = sat_q | quo_q[TIME_W-1];
  assign div_res  = sat_nx ? '1 : quo_nx;
  assign div_last = (cnt_q == CW'(1));
  assign in_div   = (state_q == ST_DIV_CR) || (state_q == ST_DIV_RU) ||
                    (state_q == ST_DIV_RD);

  assign sq_final = (p_q <= PW'(x_q[XW-1:1])) ? cand : res_q;
  assign sum3     = (TIME_W+2)'(ru_q) + (TIME_W+2)'(ct_q) + (TIME_W+2)'(rd_q);

  always_comb begin
    state_d = state_q;
    x_d = x_q;  y_d = y_q;
    res_d = res_q;  bit_d = bit_q;
    num_d = num_q;  den_d = den_q;  rem_d = rem_q;
    quo_d = quo_q;  sat_d = sat_q;  cnt_d = cnt_q;
    peak_d = peak_q;  ru_d = ru_q;  ct_d = ct_q;  rd_d = rd_q;
    tot_d = tot_q;  pe_d = pe_q;

    if (in_div) begin
      num_d = {num_q[NW-2:0], 1'b0};
      rem_d = rem_nx[DW-1:0];
      quo_d = quo_nx;
      sat_d = sat_nx;
      cnt_d = cnt_q - CW'(1);
    end

    unique case (state_q)
      ST_IDLE:  state_d = ST_IDLE;
      ST_M_LEN: state_d = ST_M_SS;
      ST_M_SS: begin
        x_d     = p_q[XW-1:0];
        state_d = ST_M_EE;
      end
      ST_M_EE: begin
        x_d     = x_q + p_q[XW-1:0];
        state_d = ST_M_CC;
      end
      ST_M_CC: begin
        x_d     = x_q + p_q[XW-1:0];
        state_d = ST_M_DEN;
      end
      ST_M_DEN: begin
        y_d     = {p_q[XW-2:0], 1'b0};
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (y_q > x_q) begin
          // Ramps overrun the path: triangle, peak from the square root
          res_d   = '0;
          bit_d   = BW'(SQW - 1);
          state_d = ST_SQ_MUL;
        end else begin
          peak_d = cruise_lim_i;
          if (cruise_lim_i == '0) begin
            ct_d    = (x_q != y_q) ? '1 : '0;
            state_d = ST_RU_SET;
          end else begin
            num_d   = {x_q - y_q, {TF{1'b0}}};
            den_d   = p_q[DW-1:0];
            rem_d   = '0;
            quo_d   = '0;
            sat_d   = 1'b0;
            cnt_d   = CW'(NW);
            state_d = ST_DIV_CR;
          end
        end
      end
      ST_SQ_MUL: state_d = ST_SQ_CHK;
      ST_SQ_CHK: begin
        res_d = sq_final;
        if (bit_q == '0) begin
          peak_d  = (sq_final > SQW'(SPEED_MAX)) ? SPEED_MAX : sq_final[SB-1:0];
          ct_d    = '0;
          state_d = ST_RU_SET;
        end else begin
          bit_d   = bit_q - BW'(1);
          state_d = ST_SQ_MUL;
        end
      end
      ST_DIV_CR: begin
        if (div_last) begin
          ct_d    = div_res;
          state_d = ST_RU_SET;
        end
      end
      ST_RU_SET: begin
        if (start_speed_i >= peak_q) begin
          ru_d    = '0;
          state_d = ST_RD_SET;
        end else begin
          num_d   = {{(XW-SB){1'b0}}, peak_q - start_speed_i, {TF{1'b0}}};
          den_d   = DW'(accel_i);
          rem_d   = '0;
          quo_d   = '0;
          sat_d   = 1'b0;
          cnt_d   = CW'(NW);
          state_d = ST_DIV_RU;
        end
      end
      ST_DIV_RU: begin
        if (div_last) begin
          ru_d    = div_res;
          state_d = ST_RD_SET;
        end
      end
      ST_RD_SET: begin
        if (end_speed_i >= peak_q) begin
          rd_d    = '0;
          state_d = ST_TOTAL;
        end else begin
          num_d   = {{(XW-SB){1'b0}}, peak_q - end_speed_i, {TF{1'b0}}};
          den_d   = DW'(accel_i);
          rem_d   = '0;
          quo_d   = '0;
          sat_d   = 1'b0;
          cnt_d   = CW'(NW);
          state_d = ST_DIV_RD;
        end
      end
      ST_DIV_RD: begin
        if (div_last) begin
          rd_d    = div_res;
          state_d = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        tot_d   = (sum3[TIME_W+1:TIME_W] != 2'b00) ? '1 : sum3[TIME_W-1:0];
        pe_d    = {1'b0, ru_q} + {1'b0, ct_q};
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // A new register write restarts the derivation
    if (start_i) begin
      state_d = ST_M_LEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      peak_q  <= '0;
      ru_q    <= '0;
      ct_q    <= '0;
      rd_q    <= '0;
      tot_q   <= '0;
      pe_q    <= '0;
    end else begin
      state_q <= state_d;
      peak_q  <= peak_d;
      ru_q    <= ru_d;
      ct_q    <= ct_d;
      rd_q    <= rd_d;
      tot_q   <= tot_d;
      pe_q    <= pe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= PW'(mul_a) * PW'(mul_b);
    x_q   <= x_d;
    y_q   <= y_d;
    res_q <= res_d;
    bit_q <= bit_d;
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
    cnt_q <= cnt_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign peak_o        = peak_q;
  assign ramp_up_o     = ru_q;
  assign plateau_end_o = pe_q;
  assign total_o       = tot_q;

endmodule

FILE: hw/rtl/tvp_checker.sv
// Port-level checks for the trapezoidal velocity profile unit, bound to the top level.
// Depends on tvp_pkg and trapezoidal_velocity_profile_unit_assert.svh.
`include "trapezoidal_velocity_profile_unit_assert.svh"

module tvp_checker #(
  parameter int SPEED_BITS = tvp_pkg::SPEED_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [SPEED_BITS-1:0]         out_speed_i,
  input logic [1:0]                    out_phase_i,
  input logic                          cfg_we_i,
  input logic [tvp_pkg::CFG_IDX_W-1:0] cfg_idx_i
);
  import tvp_pkg::*;

  // Hold a stalled result
  `TVP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_speed_i) && $stable(out_phase_i), "stalled result changed")

  // A register write starts a profile recompute that blocks samples
  `TVP_ASSERT_NEXT(a_cfg_blocks, clk_i, rst_ni, cfg_we_i && (cfg_idx_i <= REG_ACCEL_LIMIT), !in_ready_i, "sample taken during profile recompute")

  // With the sink ready a transferred sample shows after four stages
  `TVP_ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i), out_valid_i, "sample lost in pipeline")

endmodule

bind trapezoidal_velocity_profile_unit tvp_checker #(
  .SPEED_BITS (SPEED_BITS)
) u_tvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (time_i.valid),
  .in_ready_i  (time_i.ready),
  .out_valid_i (cmd_o.valid),
  .out_ready_i (cmd_o.ready),
  .out_speed_i (cmd_o.speed),
  .out_phase_i (cmd_o.phase),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);

FILE: tb/sv/trapezoidal_velocity_profile_unit_tb.sv
// Self-checking testbench for trapezoidal_velocity_profile_unit.
// Depends on tvp_pkg, tvp_in_if, tvp_out_if and the unit itself; a directed table
// comes first, then random register settings and time samples checked by a predictor.
module trapezoidal_velocity_profile_unit_tb;
  import tvp_pkg::*;

  localparam int SPD_W = SPEED_BITS_DEF;
  localparam int FRAC  = TIME_FRAC_BITS_DEF;
  localparam int DAT_W = (SPD_W > LEN_W) ? SPD_W : LEN_W;
  localparam logic [SPD_W-1:0]  SPD_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef struct {
    logic [SPD_W-1:0] speed;
    phase_e           phase;
  } cmd_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DAT_W-1:0]     data;
    logic [TIME_W-1:0]    t;
    bit                   typed;
    cmd_t                 cmd;
  } row_t;

  typedef struct {
    bit   typed;
    cmd_t cmd;
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DAT_W-1:0] cfg_data_i = '0;

  tvp_in_if tin ();
  tvp_out_if #(.SPEED_BITS(SPD_W)) cout ();

  trapezoidal_velocity_profile_unit #(
    .SPEED_BITS(SPD_W),
    .TIME_FRAC_BITS(FRAC)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .time_i(tin),
    .cmd_o(cout),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Register shadow and the profile derived from it.
  logic [LEN_W-1:0]  sh_len;
  logic [SPD_W-1:0]  sh_start, sh_end, sh_cruise;
  logic [ACC_W-1:0]  sh_acc;
  logic [SPD_W-1:0]  pf_peak;
  logic [TIME_W-1:0] pf_up, pf_cruise, pf_down, pf_total;

  cmd_t     cmd_q[$];      // expected commands, oldest first
  pending_t sent_q[$];     // what each sent sample expects, typed or predicted
  int       errors = 0;
  bit       quiet = 1'b0;  // no gaps or stalls while set
  int       stall_left = 0;

  initial begin
    tin.valid = 1'b0;
    tin.elapsed_time = '0;
    cout.ready = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous fixed bound on the whole run.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [TIME_W-1:0] ramp_of(logic [SPD_W-1:0] peak, from,
                                                logic [ACC_W-1:0] acc);
    logic [127:0] q;
    if (from >= peak) return '0;
    q = ({64'd0, 64'(peak - from)} << FRAC) / acc;
    return (q > TIME_MAX) ? TIME_MAX : q[TIME_W-1:0];
  endfunction

  // Rebuild the profile from the register shadow.
  task automatic derive_profile();
    logic [127:0] acc, x, y, half, cand, num, q, root, sum;
    acc = (sh_acc == '0) ? 128'd1 : 128'(sh_acc);
    x = 2 * acc * sh_len + 128'(sh_start) * sh_start + 128'(sh_end) * sh_end;
    y = 2 * 128'(sh_cruise) * sh_cruise;
    if (y > x) begin
      half = x >> 1;
      root = '0;
      for (int b = 40; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= half) root = cand;
      end
      pf_peak = (root > SPD_MAX) ? SPD_MAX : root[SPD_W-1:0];
      pf_cruise = '0;
    end else begin
      pf_peak = sh_cruise;
      num = (x - y) << FRAC;
      if (sh_cruise == '0) begin
        pf_cruise = (num != '0) ? TIME_MAX : '0;
      end else begin
        q = num / (2 * acc * sh_cruise);
        pf_cruise = (q > TIME_MAX) ? TIME_MAX : q[TIME_W-1:0];
      end
    end
    pf_up = ramp_of(pf_peak, sh_start, acc[ACC_W-1:0]);
    pf_down = ramp_of(pf_peak, sh_end, acc[ACC_W-1:0]);
    sum = 128'(pf_up) + pf_cruise + pf_down;
    pf_total = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
  endtask

  function automatic cmd_t command_at(logic [TIME_W-1:0] t);
    cmd_t c;
    logic [63:0] acc, plateau, v;
    acc = (sh_acc == '0) ? 64'd1 : 64'(sh_acc);
    plateau = 64'(pf_up) + pf_cruise;
    if (t < pf_up) begin
      v = 64'(sh_start) + ((acc * t) >> FRAC);
      c.speed = (v > SPD_MAX) ? SPD_MAX : v[SPD_W-1:0];
      c.phase = PH_ACCEL;
    end else if (64'(t) < plateau) begin
      c.speed = pf_peak;
      c.phase = PH_CRUISE;
    end else if (t < pf_total) begin
      v = (acc * (64'(t) - plateau)) >> FRAC;
      c.speed = (v >= pf_peak) ? '0 : pf_peak - v[SPD_W-1:0];
      c.phase = PH_DECEL;
    end else begin
      c.speed = sh_end;
      c.phase = PH_DONE;
    end
    return c;
  endfunction

  // Receiver: random stalls, none while quiet.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      cout.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      cout.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // On each input transfer, queue the expected command.
  always @(posedge clk_i) begin
    pending_t p;
    if (rst_ni && tin.valid && tin.ready) begin
      if (sent_q.size() == 0) begin
        $display("%0t: transfer on time_i with nothing sent", $time);
        errors++;
      end else begin
        p = sent_q.pop_front();
        cmd_q.insert(cmd_q.size(), p.typed ? p.cmd : command_at(tin.elapsed_time));
      end
    end
  end

  // On each output transfer, compare against the oldest expectation.
  always @(posedge clk_i) begin
    cmd_t e;
    if (rst_ni && cout.valid && cout.ready) begin
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected command speed=%h phase=%0d", $time, cout.speed,
                 cout.phase);
        errors++;
      end else begin
        e = cmd_q.pop_front();
        if (cout.speed !== e.speed) begin
          $display("%0t: speed expected %h actual %h", $time, e.speed, cout.speed);
          errors++;
        end
        if (cout.phase !== e.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, e.phase, cout.phase);
          errors++;
        end
      end
    end
  end

  // Send one sample; hold valid until the transfer happens.
  task automatic send_time(logic [TIME_W-1:0] t, bit typed, cmd_t c);
    pending_t p;
    int g;
    g = gap_len();
    if (g > 0) begin
      tin.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    p.typed = typed;
    p.cmd = c;
    sent_q.insert(sent_q.size(), p);
    tin.valid <= 1'b1;
    tin.elapsed_time <= t;
    do @(posedge clk_i); while (!tin.ready);
  endtask

  // Write a register once the pipeline has drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DAT_W-1:0] data);
    tin.valid <= 1'b0;
    @(posedge clk_i);
    while (cmd_q.size() != 0 || sent_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PATH_LENGTH:  sh_len = data[LEN_W-1:0];
      REG_START_SPEED:  sh_start = data[SPD_W-1:0];
      REG_END_SPEED:    sh_end = data[SPD_W-1:0];
      REG_CRUISE_LIMIT: sh_cruise = data[SPD_W-1:0];
      REG_ACCEL_LIMIT:  sh_acc = data[ACC_W-1:0];
      default:          return;
    endcase
    derive_profile();
  endtask

  function automatic logic [DAT_W-1:0] pick_reg_val();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return DAT_W'($urandom);
      default: return DAT_W'($urandom_range(1, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W:0] hi;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom;
    if (r == 2) begin
      case ($urandom_range(0, 5))
        0: return pf_up - 1;
        1: return pf_up;
        2: return pf_up + pf_cruise;
        3: return pf_up + pf_cruise - 1;
        4: return pf_total - 1;
        default: return pf_total;
      endcase
    end
    hi = (pf_total == '0) ? 33'h3FFFF : 33'(pf_total) + (pf_total >> 3);
    if (hi > TIME_MAX) hi = TIME_MAX;
    return $urandom_range(0, hi[TIME_W-1:0]);
  endfunction

  function automatic row_t smp(logic [TIME_W-1:0] t, bit typed = 0,
                               logic [SPD_W-1:0] s = '0, phase_e ph = PH_DONE);
    row_t r;
    r.is_cfg = 0; r.idx = '0; r.data = '0; r.t = t; r.typed = typed;
    r.cmd.speed = s; r.cmd.phase = ph;
    return r;
  endfunction

  function automatic row_t wr(logic [CFG_IDX_W-1:0] idx, logic [DAT_W-1:0] d);
    row_t r;
    r = smp('0);
    r.is_cfg = 1; r.idx = idx; r.data = d;
    return r;
  endfunction

  initial begin
    row_t dir[$];
    logic [CFG_IDX_W-1:0] idx;
    cmd_t none;
    none.speed = '0;
    none.phase = PH_DONE;

    sh_len = '0; sh_start = '0; sh_end = '0;
    sh_cruise = SPD_W'(CRUISE_RST); sh_acc = ACC_W'(ACCEL_RST);
    derive_profile();

    // Reset profile is empty: every time is past the end at end speed zero.
    dir.insert(dir.size(), smp('0, 1, '0, PH_DONE));
    dir.insert(dir.size(), smp(TIME_MAX, 1, '0, PH_DONE));
    // Writes past the register list change nothing.
    dir.insert(dir.size(), wr(IDX_UNUSED_LO, '1));
    dir.insert(dir.size(), wr(IDX_UNUSED_HI, '1));
    dir.insert(dir.size(), smp(32'h1, 1, '0, PH_DONE));
    // Plain trapezoid with nonzero start and end speeds.
    dir.insert(dir.size(), wr(REG_PATH_LENGTH, 24'h006400));
    dir.insert(dir.size(), wr(REG_START_SPEED, 24'h000A00));
    dir.insert(dir.size(), wr(REG_END_SPEED, 24'h000500));
    dir.insert(dir.size(), wr(REG_CRUISE_LIMIT, 24'h002800));
    dir.insert(dir.size(), wr(REG_ACCEL_LIMIT, 24'h006400));
    dir.insert(dir.size(), smp(32'h0));
    dir.insert(dir.size(), smp(32'h8000));
    dir.insert(dir.size(), smp(32'h10000));
    dir.insert(dir.size(), smp(32'h30000));
    dir.insert(dir.size(), smp(TIME_MAX, 1, 24'h000500, PH_DONE));
    // Zero acceleration acts as one.
    dir.insert(dir.size(), wr(REG_ACCEL_LIMIT, '0));
    dir.insert(dir.size(), smp(32'h10000));
    dir.insert(dir.size(), smp(32'h7FFF_0000));
    // Zero cruise limit with distance left over: cruise time saturates.
    dir.insert(dir.size(), wr(REG_ACCEL_LIMIT, 24'h000100));
    dir.insert(dir.size(), wr(REG_CRUISE_LIMIT, '0));
    dir.insert(dir.size(), smp(32'h1000));
    // Start speed above the peak: the up ramp collapses.
    dir.insert(dir.size(), wr(REG_CRUISE_LIMIT, 24'h000100));
    dir.insert(dir.size(), wr(REG_START_SPEED, 24'h001000));
    dir.insert(dir.size(), smp(32'h5));
    // Every register at its maximum.
    dir.insert(dir.size(), wr(REG_PATH_LENGTH, '1));
    dir.insert(dir.size(), wr(REG_START_SPEED, '1));
    dir.insert(dir.size(), wr(REG_END_SPEED, '1));
    dir.insert(dir.size(), wr(REG_CRUISE_LIMIT, '1));
    dir.insert(dir.size(), wr(REG_ACCEL_LIMIT, '1));
    dir.insert(dir.size(), smp('0));
    dir.insert(dir.size(), smp(32'h7FFF_FFFF));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) begin
      if (dir[i].is_cfg) write_reg(dir[i].idx, dir[i].data);
      else send_time(dir[i].t, dir[i].typed, dir[i].cmd);
    end

    // Random register settings, each followed by a burst of samples.
    for (int p = 0; p < 20; p++) begin
      quiet = (p % 4 == 0);
      if (p == 0) begin
        for (int r = REG_PATH_LENGTH; r <= REG_ACCEL_LIMIT; r++)
          write_reg(CFG_IDX_W'(r), pick_reg_val());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          idx = CFG_IDX_W'($urandom_range(REG_PATH_LENGTH, REG_ACCEL_LIMIT));
          write_reg(idx, pick_reg_val());
        end
      end
      repeat (100) send_time(pick_time(), 0, none);
    end

    tin.valid <= 1'b0;
    quiet = 1'b0;
    for (int w = 0; w < 100000 && (cmd_q.size() != 0 || sent_q.size() != 0); w++)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && cmd_q.size() == 0 && sent_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tvp_pkg.sv
hw/rtl/tvp_in_if.sv
hw/rtl/tvp_out_if.sv
hw/rtl/tvp_deriv.sv
hw/rtl/trapezoidal_velocity_profile_unit.sv
hw/rtl/tvp_checker.sv
tb/sv/trapezoidal_velocity_profile_unit_tb.sv
